>>> rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed (same cycle)");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed (next cycle)");

`endif

>>> rtl/i2crs_pkg.sv
`default_nettype none

package i2crs_pkg;

  localparam int unsigned ADDR_W = 7;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IN_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 16;
  localparam logic [BYTE_W-1:0] ACK_WINDOW_RESET = 8'd250;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START_A = 4'd1,
    PH_START_B = 4'd2,
    PH_START_C = 4'd3,
    PH_TX_BIT  = 4'd4,
    PH_TX_HOLD = 4'd5,
    PH_TX_REL  = 4'd6,
    PH_TX_SET  = 4'd7,
    PH_TX_ACK  = 4'd8,
    PH_RX_BIT  = 4'd9,
    PH_RX_RESP = 4'd10,
    PH_STOP_A  = 4'd11,
    PH_STOP_B  = 4'd12,
    PH_MSTOP_A = 4'd13,
    PH_MSTOP_B = 4'd14
  } phase_t;

  typedef enum logic [1:0] {
    STG_ADDR_WR = 2'd0,
    STG_REG     = 2'd1,
    STG_ADDR_RD = 2'd2
  } stage_t;

  typedef struct packed {
    logic                  kind;
    logic                  sda_in;
    logic [ADDR_W-1:0]     device_addr;
    logic [BYTE_W-1:0]     reg_addr;
    logic [BYTE_W-1:0]     read_length;
    logic                  with_register;
  } item_t;

  typedef struct packed {
    logic              scl_out;
    logic              sda_out;
    logic              sda_drive;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              last_byte;
    logic              done_res;
    logic              failed;
    logic              busy_res;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/i2c_master_read_sequencer_top.sv
`default_nettype none

// I2C master read sequencer. Every transaction on the input stream advances the
// bus by one timing unit (kind 0, carrying the SDA level sampled during that tick)
// or issues a read command (kind 1), and every input transaction yields exactly
// one result transaction that reports the SCL/SDA levels to drive for that tick,
// any data byte completed on it, and the done/failed/busy status. A command is
// taken only while the bus is idle; in register mode the engine writes the register
// address, issues a stop and a fresh start, then reads read_length bytes, while in
// simple mode it goes straight to the address-read phase. The slave acknowledge is
// awaited for ack_window ticks (a value of zero acts as one), and a missing
// acknowledge ends the transfer with a stop and the failed flag. The design takes
// one item per clock while the result side is not stalled: an input register feeds
// a single pass of sequencer logic whose result lands in an output register, so
// throughput is one transaction per cycle while no stall holds it. A result is
// valid once it has passed the input register and then the output register. A
// stall on the result side holds both registers, and s_axis_tready falls in the
// same cycle once the input register holds a transaction.
// ack_window should only be written while no command is in flight.
module i2c_master_read_sequencer_top (
  input  wire        clk,
  input  wire        rst,
  // Configuration: ack_window.
  input  wire        cfg_we,
  input  wire [7:0]  cfg_wdata,
  // Input stream.
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  // tdata from bit 0: sda_in, device_addr[6:0], reg_addr[7:0], read_length[7:0],
  // with_register, zero fill.
  input  wire [i2crs_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // tuser: kind (0 = tick, 1 = command).
  input  wire        s_axis_tuser,
  // Result stream.
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  // tdata from bit 0: scl_out, sda_out, sda_drive, byte_valid, byte_data[7:0],
  // done_res, failed, busy_res, zero fill.
  output logic [i2crs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tlast: last_byte.
  output logic       m_axis_tlast
);

  logic [i2crs_pkg::BYTE_W-1:0] ack_window;
  logic                         in_valid;
  i2crs_pkg::item_t             in_item;
  i2crs_pkg::item_t             s_item;
  logic                         advance;
  logic                         accept;
  i2crs_pkg::result_t           step_res;
  i2crs_pkg::result_t           out_res;

  always_comb begin
    s_item.kind          = s_axis_tuser;
    s_item.sda_in        = s_axis_tdata[0];
    s_item.device_addr   = s_axis_tdata[7:1];
    s_item.reg_addr      = s_axis_tdata[15:8];
    s_item.read_length   = s_axis_tdata[23:16];
    s_item.with_register = s_axis_tdata[24];
  end

  // The sequencer steps when the input register holds a transaction and the
  // result register is empty or being drained this cycle.
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_window <= i2crs_pkg::ACK_WINDOW_RESET;
    end else if (cfg_we) begin
      ack_window <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= s_item;
    end
  end

  i2crs_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (in_item),
    .ack_window (ack_window),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tdata = {1'b0, out_res.busy_res, out_res.failed, out_res.done_res,
                         out_res.byte_data, out_res.byte_valid, out_res.sda_drive,
                         out_res.sda_out, out_res.scl_out};
  assign m_axis_tlast = out_res.last_byte;

endmodule

`default_nettype wire

>>> rtl/i2crs_seq.sv
`default_nettype none
`include "assert_macros.svh"

module i2crs_seq (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         advance,
  input  i2crs_pkg::item_t            item,
  input  wire [i2crs_pkg::BYTE_W-1:0] ack_window,
  output i2crs_pkg::result_t          res
);

  typedef struct packed {
    i2crs_pkg::phase_t              phase;
    logic [2:0]                     phase_timer;
    logic [2:0]                     bit_count;
    logic [i2crs_pkg::BYTE_W-1:0]   shift_reg;
    logic [i2crs_pkg::BYTE_W-1:0]   bytes_left;
    logic [i2crs_pkg::BYTE_W-1:0]   ack_timer;
    logic [i2crs_pkg::ADDR_W-1:0]   saved_addr;
    logic [i2crs_pkg::BYTE_W-1:0]   saved_reg;
    logic                           saved_mode;
    i2crs_pkg::stage_t              send_stage;
    logic                           ack_seen;
  } seq_state_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } bus_t;

  seq_state_t st, st_next, st_cmd;
  bus_t       bus;

  // Bus levels that a given state drives.
  function automatic bus_t levels(seq_state_t s);
    bus_t b;
    b = '{scl: 1'b1, sda: 1'b1, drv: 1'b0};
    case (s.phase)
      i2crs_pkg::PH_START_A: b.drv = 1'b1;
      i2crs_pkg::PH_START_B: begin
        b.sda = 1'b0;
        b.drv = 1'b1;
      end
      i2crs_pkg::PH_START_C, i2crs_pkg::PH_STOP_A, i2crs_pkg::PH_MSTOP_A: begin
        b = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
      end
      i2crs_pkg::PH_TX_BIT: begin
        b.scl = (s.phase_timer == 3'd2);
        b.sda = s.shift_reg[~s.bit_count];
        b.drv = 1'b1;
      end
      i2crs_pkg::PH_TX_HOLD: begin
        b.scl = 1'b0;
        b.sda = s.shift_reg[0];
        b.drv = 1'b1;
      end
      i2crs_pkg::PH_TX_REL: b.scl = 1'b0;
      i2crs_pkg::PH_RX_BIT: b.scl = (s.phase_timer == 3'd1);
      i2crs_pkg::PH_RX_RESP: begin
        b.scl = (s.phase_timer == 3'd1);
        b.sda = (s.bytes_left == '0);
        b.drv = 1'b1;
      end
      i2crs_pkg::PH_STOP_B, i2crs_pkg::PH_MSTOP_B: b.drv = 1'b1;
      default: b = '{scl: 1'b1, sda: 1'b1, drv: 1'b0};
    endcase
    return b;
  endfunction

  // Stay until the timer reaches its last count, then move on with a fresh timer.
  function automatic seq_state_t timed(seq_state_t s, logic [2:0] last,
                                       i2crs_pkg::phase_t nxt);
    seq_state_t r;
    r = s;
    if (s.phase_timer >= last) begin
      r.phase = nxt;
      r.phase_timer = '0;
    end else begin
      r.phase_timer = s.phase_timer + 3'd1;
    end
    return r;
  endfunction

  // A command only loads the transaction when the bus is idle.
  always_comb begin
    st_cmd = st;
    if (st.phase == i2crs_pkg::PH_IDLE) begin
      st_cmd.saved_addr  = item.device_addr;
      st_cmd.saved_reg   = item.reg_addr;
      st_cmd.bytes_left  = item.read_length;
      st_cmd.saved_mode  = item.with_register;
      st_cmd.ack_seen    = 1'b0;
      st_cmd.bit_count   = '0;
      st_cmd.ack_timer   = '0;
      st_cmd.send_stage  = item.with_register ? i2crs_pkg::STG_ADDR_WR
                                              : i2crs_pkg::STG_ADDR_RD;
      st_cmd.shift_reg   = {item.device_addr, ~item.with_register};
      st_cmd.phase       = i2crs_pkg::PH_START_A;
      st_cmd.phase_timer = '0;
    end
  end

  always_comb begin
    st_next = st;
    res = '0;
    if (item.kind) begin
      st_next = st_cmd;
      bus = levels(st_cmd);
    end else begin
      bus = levels(st);
      case (st.phase)
        i2crs_pkg::PH_START_A: st_next = timed(st, 3'd4, i2crs_pkg::PH_START_B);
        i2crs_pkg::PH_START_B: st_next = timed(st, 3'd4, i2crs_pkg::PH_START_C);
        i2crs_pkg::PH_START_C: begin
          st_next = timed(st, 3'd4, i2crs_pkg::PH_TX_BIT);
          st_next.bit_count = '0;
        end
        i2crs_pkg::PH_TX_BIT: begin
          if (st.phase_timer < 3'd2) begin
            st_next.phase_timer = st.phase_timer + 3'd1;
          end else if (st.bit_count == 3'd7) begin
            st_next.bit_count = '0;
            st_next.phase = i2crs_pkg::PH_TX_HOLD;
            st_next.phase_timer = '0;
          end else begin
            st_next.bit_count = st.bit_count + 3'd1;
            st_next.phase_timer = '0;
          end
        end
        i2crs_pkg::PH_TX_HOLD: st_next = timed(st, 3'd2, i2crs_pkg::PH_TX_REL);
        i2crs_pkg::PH_TX_REL:  st_next = timed(st, 3'd2, i2crs_pkg::PH_TX_SET);
        i2crs_pkg::PH_TX_SET: begin
          st_next.ack_timer = '0;
          st_next.phase = i2crs_pkg::PH_TX_ACK;
          st_next.phase_timer = '0;
        end
        i2crs_pkg::PH_TX_ACK: begin
          if (!item.sda_in) begin
            st_next.phase_timer = '0;
            case (st.send_stage)
              i2crs_pkg::STG_ADDR_WR: begin
                st_next.send_stage = i2crs_pkg::STG_REG;
                st_next.shift_reg = st.saved_reg;
                st_next.bit_count = '0;
                st_next.phase = i2crs_pkg::PH_TX_BIT;
              end
              i2crs_pkg::STG_REG: begin
                st_next.send_stage = i2crs_pkg::STG_ADDR_RD;
                st_next.phase = i2crs_pkg::PH_MSTOP_A;
              end
              default: begin
                st_next.ack_seen = 1'b1;
                st_next.bit_count = '0;
                st_next.shift_reg = '0;
                st_next.phase = (st.bytes_left == '0) ? i2crs_pkg::PH_STOP_A
                                                      : i2crs_pkg::PH_RX_BIT;
              end
            endcase
          end else begin
            st_next.ack_timer = st.ack_timer + 8'd1;
            if (st_next.ack_timer >= ack_window) begin
              st_next.ack_seen = 1'b0;
              st_next.phase = i2crs_pkg::PH_STOP_A;
              st_next.phase_timer = '0;
            end
          end
        end
        i2crs_pkg::PH_RX_BIT: begin
          if (st.phase_timer == '0) begin
            st_next.phase_timer = 3'd1;
          end else begin
            st_next.shift_reg = {st.shift_reg[i2crs_pkg::BYTE_W-2:0], item.sda_in};
            if (st.bit_count == 3'd7) begin
              res.byte_valid = 1'b1;
              res.byte_data = st_next.shift_reg;
              res.last_byte = (st.bytes_left == 8'd1);
              st_next.bytes_left = st.bytes_left - 8'd1;
              st_next.bit_count = '0;
              st_next.phase = i2crs_pkg::PH_RX_RESP;
              st_next.phase_timer = '0;
            end else begin
              st_next.bit_count = st.bit_count + 3'd1;
              st_next.phase_timer = '0;
            end
          end
        end
        i2crs_pkg::PH_RX_RESP: begin
          if (st.phase_timer == '0) begin
            st_next.phase_timer = 3'd1;
          end else begin
            st_next.shift_reg = '0;
            st_next.bit_count = '0;
            st_next.phase = (st.bytes_left == '0) ? i2crs_pkg::PH_STOP_A
                                                  : i2crs_pkg::PH_RX_BIT;
            st_next.phase_timer = '0;
          end
        end
        i2crs_pkg::PH_STOP_A: st_next = timed(st, 3'd3, i2crs_pkg::PH_STOP_B);
        i2crs_pkg::PH_STOP_B: begin
          st_next = timed(st, 3'd3, i2crs_pkg::PH_IDLE);
          if (st.phase_timer >= 3'd3) begin
            res.done_res = 1'b1;
            res.failed = ~st.ack_seen;
          end
        end
        i2crs_pkg::PH_MSTOP_A: st_next = timed(st, 3'd3, i2crs_pkg::PH_MSTOP_B);
        i2crs_pkg::PH_MSTOP_B: begin
          st_next = timed(st, 3'd3, i2crs_pkg::PH_START_A);
          if (st.phase_timer >= 3'd3) begin
            st_next.shift_reg = {st.saved_addr, 1'b1};
          end
        end
        default: begin
          st_next.phase = i2crs_pkg::PH_IDLE;
          st_next.phase_timer = '0;
        end
      endcase
    end
    res.scl_out = bus.scl;
    res.sda_out = bus.sda;
    res.sda_drive = bus.drv;
    res.busy_res = (st_next.phase != i2crs_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  `ASSERT_NEXT(a_byte_then_answer, clk, rst, advance && res.byte_valid, st.phase == i2crs_pkg::PH_RX_RESP)
  `ASSERT_NEXT(a_done_then_idle, clk, rst, advance && res.done_res, st.phase == i2crs_pkg::PH_IDLE)
  `ASSERT_SAME(a_idle_timer_clear, clk, rst, st.phase == i2crs_pkg::PH_IDLE, st.phase_timer == '0)
  `ASSERT_SAME(a_release_on_ack, clk, rst, st.phase == i2crs_pkg::PH_TX_ACK && !item.kind, !res.sda_drive && res.scl_out)

endmodule

`default_nettype wire
